[rtl/core/xrs_pkg.sv]
package xrs_pkg;

   localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] SM_MUL2  = 64'h94d049bb133111eb;

   localparam int unsigned SM_SHIFT1 = 30;
   localparam int unsigned SM_SHIFT2 = 27;
   localparam int unsigned SM_SHIFT3 = 31;

   localparam int unsigned ROT_A   = 24;
   localparam int unsigned SHIFT_B = 16;
   localparam int unsigned ROT_C   = 37;

   localparam int unsigned REM_STEPS = 64;

   localparam logic [1:0] FUNC_DRAW64  = 2'd0;
   localparam logic [1:0] FUNC_DRAW32  = 2'd1;
   localparam logic [1:0] FUNC_BOUNDED = 2'd2;

   localparam logic [1:0] MUL_STEP_LL = 2'd0;
   localparam logic [1:0] MUL_STEP_LH = 2'd1;
   localparam logic [1:0] MUL_STEP_HL = 2'd2;
   localparam logic [1:0] MUL_STEP_ACC = 2'd3;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] range_low;
      logic signed [31:0] range_high;
   } req_type;

   typedef struct packed {
      logic [63:0]        value;
      logic signed [31:0] int_value;
      logic               bad_range;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_SEED_ADD,
      ST_SEED_MUL1,
      ST_SEED_MUL2,
      ST_IDLE,
      ST_EXEC,
      ST_LIMIT,
      ST_DRAW,
      ST_REDUCE,
      ST_DONE
   } state_type;

   function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned k);
      rotl64 = (x << k) | (x >> (64 - k));
   endfunction

endpackage

[rtl/core/xrs_mul_unit.sv]
module xrs_mul_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] product
);
   import xrs_pkg::*;

   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] mul_x;
   logic [31:0] mul_y;

   always_comb begin
      mul_x = a_ff[31:0];
      mul_y = b_ff[31:0];
      case (step_ff)
         MUL_STEP_LH: begin
            mul_y = b_ff[63:32];
         end
         MUL_STEP_HL: begin
            mul_x = a_ff[63:32];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         step_in = MUL_STEP_LL;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = 64'(mul_x) * 64'(mul_y);
         step_in = step_ff + 2'd1;
         case (step_ff)
            MUL_STEP_LL: begin
            end
            MUL_STEP_LH: begin
               acc_in = prod_ff;
            end
            MUL_STEP_HL: begin
               acc_in = acc_ff + {prod_ff[31:0], 32'b0};
            end
            MUL_STEP_ACC: begin
               acc_in  = acc_ff + {prod_ff[31:0], 32'b0};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= MUL_STEP_LL;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[rtl/core/xrs_rem_unit.sv]
module xrs_rem_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic [31:0] remainder
);
   import xrs_pkg::*;

   localparam int unsigned CntWidth = $clog2(REM_STEPS);

   logic [63:0]         n_ff, n_in;
   logic [32:0]         d_ff, d_in;
   logic [31:0]         r_ff, r_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [32:0]         trial;

   assign trial = {r_ff, n_ff[63]};

   always_comb begin
      n_in    = n_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = dividend;
         d_in    = divisor;
         r_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in   = {n_ff[62:0], 1'b0};
         cnt_in = cnt_ff + CntWidth'(1);
         if (trial >= d_ff) begin
            r_in = 32'(trial - d_ff);
         end else begin
            r_in = trial[31:0];
         end
         if (cnt_ff == CntWidth'(REM_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff <= n_in;
      d_ff <= d_in;
      r_ff <= r_in;
   end

   assign done      = done_ff;
   assign remainder = r_ff;

endmodule

[rtl/core/xoroshiro128plus_generator.sv]
// 64-bit and 32-bit draws go from EXEC to DONE, where the result is staged.
// Bounded draws pass through LIMIT, DRAW (again for each rejected draw) and REDUCE,
// making two 64-step passes through the one shared bit-serial remainder unit.
// Throughput: one request at a time, taken the cycle after the previous result is staged.
// Reset and each seed write run splitmix64 twice through the shared 32x32 multiplier;
// no request is taken until seeding is done.
module xoroshiro128plus_generator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  xrs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output xrs_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [63:0]      csr_wr_data
);
   import xrs_pkg::*;

   state_type   state_ff, state_in;
   logic [63:0] mix_acc_ff, mix_acc_in;
   logic        half_ff, half_in;
   logic [63:0] gen_low_ff, gen_low_in;
   logic [63:0] gen_high_ff, gen_high_in;
   req_type     req_ff, req_in;
   logic [32:0] span_ff, span_in;
   logic [63:0] limit_ff, limit_in;
   rsp_type     res_ff, res_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        mul_start;
   logic [63:0] mul_a;
   logic [63:0] mul_b;
   logic        mul_done;
   logic [63:0] mul_product;
   logic        rem_start;
   logic [63:0] rem_n;
   logic [32:0] rem_d;
   logic        rem_done;
   logic [31:0] rem_value;

   logic [63:0] acc_next;
   logic [63:0] draw_sum;
   logic [63:0] draw_x;
   logic [63:0] next_low;
   logic [63:0] next_high;
   logic        reject;
   logic        range_bad;
   logic [32:0] span_diff;
   logic [32:0] span_c;
   logic        out_free;
   logic        accept;

   xrs_mul_unit u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   xrs_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_n),
      .divisor   (rem_d),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign acc_next  = mix_acc_ff + SM_GAMMA;
   assign draw_sum  = gen_low_ff + gen_high_ff;
   assign draw_x    = gen_low_ff ^ gen_high_ff;
   assign next_low  = rotl64(gen_low_ff, ROT_A) ^ draw_x ^ (draw_x << SHIFT_B);
   assign next_high = rotl64(draw_x, ROT_C);
   assign reject    = draw_sum >= limit_ff;
   assign range_bad = req_ff.range_high < req_ff.range_low;
   assign span_diff = {req_ff.range_high[31], req_ff.range_high}
                      - {req_ff.range_low[31], req_ff.range_low};
   assign span_c    = span_diff + 33'd1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SEED_ADD: begin
            state_in = ST_SEED_MUL1;
         end
         ST_SEED_MUL1: begin
            if (mul_done) begin
               state_in = ST_SEED_MUL2;
            end
         end
         ST_SEED_MUL2: begin
            if (mul_done) begin
               state_in = half_ff ? ST_IDLE : ST_SEED_ADD;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (req_ff.func == FUNC_BOUNDED && !range_bad) begin
               state_in = ST_LIMIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_LIMIT: begin
            if (rem_done) begin
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            if (!reject) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (rem_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_wr_en) begin
         state_in = ST_SEED_ADD;
      end
   end

   always_comb begin
      mul_start = 1'b0;
      mul_a     = mul_product ^ (mul_product >> SM_SHIFT2);
      mul_b     = SM_MUL2;
      rem_start = 1'b0;
      rem_n     = draw_sum;
      rem_d     = span_ff;
      req_stall = 1'b1;
      case (state_ff)
         ST_SEED_ADD: begin
            mul_start = 1'b1;
            mul_a     = acc_next ^ (acc_next >> SM_SHIFT1);
            mul_b     = SM_MUL1;
         end
         ST_SEED_MUL1: begin
            mul_start = mul_done;
         end
         ST_IDLE: begin
            req_stall = csr_wr_en;
         end
         ST_EXEC: begin
            rem_start = req_ff.func == FUNC_BOUNDED && !range_bad;
            rem_n     = '1;
            rem_d     = span_c;
         end
         ST_DRAW: begin
            rem_start = !reject;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      mix_acc_in   = mix_acc_ff;
      half_in      = half_ff;
      gen_low_in   = gen_low_ff;
      gen_high_in  = gen_high_ff;
      req_in       = req_ff;
      span_in      = span_ff;
      limit_in     = limit_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_SEED_ADD: begin
            mix_acc_in = acc_next;
         end
         ST_SEED_MUL2: begin
            if (mul_done) begin
               if (half_ff) begin
                  gen_high_in = mul_product ^ (mul_product >> SM_SHIFT3);
               end else begin
                  gen_low_in = mul_product ^ (mul_product >> SM_SHIFT3);
                  half_in    = 1'b1;
               end
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
            end
         end
         ST_EXEC: begin
            res_in = '0;
            case (req_ff.func)
               FUNC_DRAW64: begin
                  res_in.value = draw_sum;
                  gen_low_in   = next_low;
                  gen_high_in  = next_high;
               end
               FUNC_DRAW32: begin
                  res_in.value = {32'b0, draw_sum[31:0]};
                  gen_low_in   = next_low;
                  gen_high_in  = next_high;
               end
               FUNC_BOUNDED: begin
                  if (range_bad) begin
                     res_in.int_value = req_ff.range_low;
                     res_in.bad_range = 1'b1;
                  end else begin
                     span_in = span_c;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_LIMIT: begin
            if (rem_done) begin
               limit_in = ~64'b0 - {32'b0, rem_value};
            end
         end
         ST_DRAW: begin
            gen_low_in  = next_low;
            gen_high_in = next_high;
         end
         ST_REDUCE: begin
            if (rem_done) begin
               res_in.int_value = signed'(32'(unsigned'(req_ff.range_low) + rem_value));
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (csr_wr_en) begin
         mix_acc_in = csr_wr_data;
         half_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SEED_ADD;
         mix_acc_ff   <= '0;
         half_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mix_acc_ff   <= mix_acc_in;
         half_ff      <= half_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      gen_low_ff  <= gen_low_in;
      gen_high_ff <= gen_high_in;
      req_ff      <= req_in;
      span_ff     <= span_in;
      limit_ff    <= limit_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted request did not start execution");

   a_mul_seed_only: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> (state_ff == ST_SEED_ADD || state_ff == ST_SEED_MUL1))
      else $error("multiplier started outside seeding");

   a_bad_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.bad_range |-> rsp_data_ff.value == 64'b0)
      else $error("bad range result carries a raw value");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && out_free |=> rsp_valid_ff)
      else $error("finished result not staged");

endmodule

[test/xoroshiro128plus_generator_test.sv]
`timescale 1ns / 100ps
module xoroshiro128plus_generator_test;
   import xrs_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic signed [31:0] RANGE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] RANGE_MAX = 32'sh7fff_ffff;
   localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_LIMIT = 5000;
   localparam int RANDOM_PHASE_ITEMS = 450;
   localparam int PAUSE_INTERVAL = 150;
   localparam int BURST_ITEMS = 40;
   localparam int MAX_REPORTS = 100;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic [63:0] csr_wr_data;

   logic [63:0] xoro_state_lo;
   logic [63:0] xoro_state_hi;
   rsp_type     pending_responses[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_orders = 0;
   int fail_count = 0;
   int report_count = 0;
   int response_count = 0;
   int bounded_count = 0;
   int inverted_count = 0;
   int seeds_loaded = 0;

   xoroshiro128plus_generator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [63:0] rotate_left(input logic [63:0] x, input int unsigned k);
      logic [127:0] doubled;
      doubled = {x, x} << k;
      return doubled[127:64];
   endfunction

   function automatic logic [63:0] splitmix_next(inout logic [63:0] acc);
      logic [63:0] z;
      acc = acc + SM_GAMMA;
      z = acc;
      z = (z ^ (z >> SM_SHIFT1)) * SM_MUL1;
      z = (z ^ (z >> SM_SHIFT2)) * SM_MUL2;
      return z ^ (z >> SM_SHIFT3);
   endfunction

   function automatic void load_generator_seed(input logic [63:0] seed_word);
      logic [63:0] acc;
      acc = seed_word;
      xoro_state_lo = splitmix_next(acc);
      xoro_state_hi = splitmix_next(acc);
   endfunction

   function automatic logic [63:0] xoro_next();
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] sum;
      a = xoro_state_lo;
      b = xoro_state_hi;
      sum = a + b;
      b = b ^ a;
      xoro_state_lo = rotate_left(a, ROT_A) ^ b ^ (b << SHIFT_B);
      xoro_state_hi = rotate_left(b, ROT_C);
      return sum;
   endfunction

   function automatic rsp_type predict_response(input req_type r);
      rsp_type            res;
      logic signed [63:0] lo_w;
      logic signed [63:0] hi_w;
      logic [63:0]        span;
      logic [63:0]        limit;
      logic [63:0]        draw;
      logic [63:0]        total;
      res = '0;
      case (r.func)
         FUNC_DRAW64: begin
            res.value = xoro_next();
         end
         FUNC_DRAW32: begin
            res.value = xoro_next() & 64'h0000_0000_ffff_ffff;
         end
         FUNC_BOUNDED: begin
            lo_w = r.range_low;
            hi_w = r.range_high;
            if (hi_w < lo_w) begin
               res.int_value = r.range_low;
               res.bad_range = 1'b1;
            end else begin
               span = hi_w - lo_w + 64'd1;
               limit = ALL_ONES - (ALL_ONES % span);
               do
                  draw = xoro_next();
               while (draw >= limit);
               total = lo_w + (draw % span);
               res.int_value = total[31:0];
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic req_type make_request(input logic [1:0] func,
                                            input logic signed [31:0] lo,
                                            input logic signed [31:0] hi);
      req_type r;
      r.func = func;
      r.range_low = lo;
      r.range_high = hi;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      longint      lo_l;
      longint      hi_l;
      longint      span_l;
      pick = $urandom_range(99);
      r.func = pick < 30 ? FUNC_DRAW64 : pick < 55 ? FUNC_DRAW32 :
               pick < 95 ? FUNC_BOUNDED : FUNC_UNUSED;
      r.range_low = $urandom();
      r.range_high = $urandom();
      if (r.func == FUNC_BOUNDED && $urandom_range(3) != 0) begin
         case ($urandom_range(2))
            0: span_l = $urandom_range(16, 1);
            1: span_l = $urandom_range(32'h0010_0000, 1);
            default: span_l = $urandom_range(32'h8000_0000, 1);
         endcase
         lo_l = r.range_low;
         hi_l = lo_l + span_l - 1;
         if (hi_l > 64'sd2147483647) begin
            hi_l = lo_l;
            lo_l = lo_l - span_l + 1;
         end
         r.range_low = lo_l[31:0];
         r.range_high = hi_l[31:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
      fail_count++;
      if (report_count < MAX_REPORTS) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      end
      report_count++;
   endtask

   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            response_count++;
            if (pending_responses.size() == 0) begin
               fail_count++;
               if (report_count < MAX_REPORTS) begin
                  $display("%0t: unexpected response: expected none, actual %h",
                           $time, rsp_data);
               end
               report_count++;
            end else begin
               want = pending_responses.pop_front();
               if (rsp_data.value !== want.value) begin
                  report_mismatch("value", want.value, rsp_data.value);
               end
               if (rsp_data.int_value !== want.int_value) begin
                  report_mismatch("int_value", want.int_value, rsp_data.int_value);
               end
               if (rsp_data.bad_range !== want.bad_range) begin
                  report_mismatch("bad_range", want.bad_range, rsp_data.bad_range);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = predict_response(req_data);
            if (req_data.func == FUNC_BOUNDED) begin
               bounded_count++;
            end
            if (want.bad_range) begin
               inverted_count++;
            end
            pending_responses.push_back(want);
         end
      end
   end

   initial begin : response_stall
      int served;
      int left;
      served = 0;
      left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (served != hold_off_orders) begin
            served = hold_off_orders;
            left = HOLD_OFF_CYCLES;
         end
         if (left > 0) begin
            left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   task automatic wait_for_responses();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_responses.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_seed(input logic [63:0] seed_word);
      wait_for_responses();
      csr_wr_data <= seed_word;
      csr_wr_en <= 1'b1;
      load_generator_seed(seed_word);
      seeds_loaded++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_reset_seed_draws();
      send_request(make_request(FUNC_DRAW64, 0, 0));
      send_request(make_request(FUNC_DRAW32, RANGE_MIN, RANGE_MAX));
      send_request(make_request(FUNC_UNUSED, -1, -1));
      wait_for_responses();
   endtask

   task automatic test_bounded_edges();
      send_request(make_request(FUNC_BOUNDED, 0, 0));
      send_request(make_request(FUNC_BOUNDED, RANGE_MIN, RANGE_MIN));
      send_request(make_request(FUNC_BOUNDED, RANGE_MAX, RANGE_MAX));
      send_request(make_request(FUNC_BOUNDED, RANGE_MIN, RANGE_MAX));
      send_request(make_request(FUNC_BOUNDED, RANGE_MAX, RANGE_MIN));
      send_request(make_request(FUNC_BOUNDED, 5, 4));
      send_request(make_request(FUNC_BOUNDED, RANGE_MIN, RANGE_MIN + 1));
      send_request(make_request(FUNC_BOUNDED, RANGE_MAX - 1, RANGE_MAX));
      send_request(make_request(FUNC_BOUNDED, -1, 0));
      send_request(make_request(FUNC_BOUNDED, 0, RANGE_MAX));
      send_request(make_request(FUNC_BOUNDED, -7, -5));
      send_request(make_request(FUNC_UNUSED, RANGE_MAX, RANGE_MIN));
      wait_for_responses();
   endtask

   task automatic test_seed_extremes();
      logic [63:0] seeds[4];
      seeds[0] = 64'h0;
      seeds[1] = ALL_ONES;
      seeds[2] = 64'h0 - SM_GAMMA;
      seeds[3] = 64'h8000_0000_0000_0000;
      foreach (seeds[i]) begin
         write_seed(seeds[i]);
         send_request(make_request(FUNC_DRAW64, 0, 0));
         send_request(make_request(FUNC_BOUNDED, RANGE_MIN, RANGE_MAX));
      end
      wait_for_responses();
   endtask

   task automatic test_back_pressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_seed({$urandom(), $urandom()});
      hold_off_orders++;
      for (int i = 0; i < BURST_ITEMS; i++) begin
         send_request(make_request($urandom_range(1) ? FUNC_DRAW64 : FUNC_DRAW32,
                                   $urandom(), $urandom()));
      end
      wait_for_responses();
   endtask

   task automatic run_random_phase(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      write_seed({$urandom(), $urandom()});
      for (int i = 1; i <= RANDOM_PHASE_ITEMS; i++) begin
         send_request(random_request());
         if (i % PAUSE_INTERVAL == 0) begin
            wait_for_responses();
         end
      end
      wait_for_responses();
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0);
      run_random_phase(54, 0);
      run_random_phase(0, 54);
      run_random_phase(7, 7);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      load_generator_seed(64'h0);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_seed_draws();
      test_bounded_edges();
      test_seed_extremes();
      test_back_pressure();
      test_random_traffic();
      wait_for_responses();
      repeat (8) @(posedge clock);
      if (pending_responses.size() != 0) begin
         fail_count += pending_responses.size();
         $display("%0t: %0d expected responses never arrived", $time,
                  pending_responses.size());
      end
      $display("Checked %0d responses: %0d bounded draws, %0d of them with an inverted range.",
               response_count, bounded_count, inverted_count);
      $display("Used %0d seed loads under idle, stalled and held-off traffic.", seeds_loaded);
      if (fail_count == 0) begin
         $display("xoroshiro128plus_generator_test OK");
      end else begin
         $display("xoroshiro128plus_generator_test NOT OK");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("%0t: timeout with %0d responses outstanding", $time, pending_responses.size());
      $display("xoroshiro128plus_generator_test NOT OK");
      $finish;
   end

endmodule
